// File: sv/fst_pkg.sv
package fst_pkg;

    // Item codes
    localparam logic [1:0] OP_BUTTONS = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_ECHO    = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_PWM_PERIOD  = 2'd0;
    localparam logic [1:0] REG_DIST_LIMIT  = 2'd1;
    localparam logic [1:0] REG_TIMER_LIMIT = 2'd2;
    localparam logic [1:0] REG_TIMER_STEP  = 2'd3;

    // Register reset values
    localparam logic [15:0] PWM_PERIOD_RST  = 16'd16799;
    localparam logic [12:0] DIST_LIMIT_RST  = 13'd300;
    localparam logic [7:0]  TIMER_LIMIT_RST = 8'd12;
    localparam logic [7:0]  TIMER_STEP_RST  = 8'd2;

    // floor(w * 343 / 2000) == (w * DIST_MUL) >> DIST_SHIFT for any 16-bit w
    localparam logic [24:0] DIST_MUL   = 25'd23018341;
    localparam int          DIST_SHIFT = 27;

    // floor(x / 5) == (x * DIV5_MUL) >> DIV5_SHIFT for any 18-bit x
    localparam logic [17:0] DIV5_MUL   = 18'd209716;
    localparam int          DIV5_SHIFT = 20;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  button_levels;
        logic [15:0] echo_width_us;
        logic        echo_ok;
    } t_in_word;

    typedef struct packed {
        logic        fan_running;
        logic [1:0]  speed_now;
        logic [15:0] pwm_compare;
        logic [2:0]  led_rgb;
        logic [7:0]  seconds_left;
        logic        timer_armed;
        logic [13:0] range_mm;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_word;

endpackage

// File: sv/fst_ifs.sv
interface fst_in_if import fst_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fst_out_if import fst_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fst_cfg_if import fst_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/fan_speed_timer_controller.sv
// Fan speed and timer controller.
// i_in carries one word per event: a button sample (three active-low levels,
// power / speed / timer), a one-second tick, or an echo measurement. Every
// accepted word yields exactly one word on o_out showing the fan state after
// that event: power, speed level, PWM compare, LED color, timer count, armed
// flag and the distance computed from an echo.
// i_cfg writes the four registers (PWM period, distance limit, timer limit,
// timer step); it is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this. An accepted word
// lands in the input register; when the result register can advance, one
// pass of logic fills it, and the fan state is updated at that same edge.
// One word is taken every cycle while the receiver keeps up; the echo
// multiply-and-compare into the state registers sets the cycle time.
// When the receiver stalls, the result register holds its word and the input
// register fills; i_in.ready drops only once both are full.
// Reset (synchronous, active low) turns the fan off, clears speed and timer,
// marks all buttons released, empties both registers and restores the
// register defaults.
module fan_speed_timer_controller import fst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fst_in_if.sink    i_in,
    fst_out_if.source o_out,
    fst_cfg_if.sink   i_cfg
);

    // Configuration registers
    logic [15:0] r_pwm_period;
    logic [12:0] r_dist_limit;
    logic [7:0]  r_timer_limit;
    logic [7:0]  r_timer_step;

    // Fan state
    logic       r_fan_on, n_fan_on;
    logic [1:0] r_speed, n_speed;
    logic [7:0] r_count, n_count;
    logic       r_tarm, n_tarm;
    logic [2:0] r_prev, n_prev;

    // Pipeline registers
    logic      r_in_v;
    t_in_word  r_in;
    logic      r_out_v;
    t_out_word r_out, n_out;

    logic w_adv;

    // Arithmetic
    logic [17:0] w_p3;
    logic [17:0] w_p4;
    logic [35:0] w_p3_prod;
    logic [35:0] w_p4_prod;
    logic [15:0] w_cmp1;
    logic [15:0] w_cmp2;
    logic [40:0] w_dist_prod;
    logic [13:0] w_dist;

    // Advance the result register when it is empty or being taken
    assign w_adv       = !r_out_v || o_out.ready;
    assign i_in.ready  = !r_in_v || w_adv;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= PWM_PERIOD_RST;
            r_dist_limit  <= DIST_LIMIT_RST;
            r_timer_limit <= TIMER_LIMIT_RST;
            r_timer_step  <= TIMER_STEP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_PWM_PERIOD:  r_pwm_period  <= i_cfg.data.data;
                REG_DIST_LIMIT:  r_dist_limit  <= i_cfg.data.data[12:0];
                REG_TIMER_LIMIT: r_timer_limit <= i_cfg.data.data[7:0];
                REG_TIMER_STEP:  r_timer_step  <= i_cfg.data.data[7:0];
                default: ;
            endcase
        end
    end

    // Compare values: period*3/5 and period*4/5 by reciprocal multiply
    assign w_p3      = 18'({2'b00, r_pwm_period}) + 18'({r_pwm_period, 1'b0});
    assign w_p4      = {r_pwm_period, 2'b00};
    assign w_p3_prod = 36'(w_p3) * 36'(DIV5_MUL);
    assign w_p4_prod = 36'(w_p4) * 36'(DIV5_MUL);
    assign w_cmp1    = w_p3_prod[DIV5_SHIFT +: 16];
    assign w_cmp2    = w_p4_prod[DIV5_SHIFT +: 16];

    // Distance: width*343/2000, zero on timeout or for other items
    assign w_dist_prod = 41'(r_in.echo_width_us) * 41'(DIST_MUL);
    assign w_dist      = (r_in.op == OP_ECHO && r_in.echo_ok) ?
                         w_dist_prod[DIST_SHIFT +: 14] : 14'd0;

    always_comb begin
        logic [2:0] falls;
        logic [8:0] sum;

        n_fan_on = r_fan_on;
        n_speed  = r_speed;
        n_count  = r_count;
        n_tarm   = r_tarm;
        n_prev   = r_prev;
        falls    = r_prev & ~r_in.button_levels;
        sum      = 9'd0;

        case (r_in.op)
            OP_BUTTONS: begin
                // Edges act in order power, speed, timer
                if (falls[0]) begin
                    if (n_fan_on) begin
                        n_fan_on = 1'b0;
                        n_speed  = 2'd0;
                        n_tarm   = 1'b0;
                        n_count  = 8'd0;
                    end else begin
                        n_fan_on = 1'b1;
                        if (n_speed == 2'd0) begin
                            n_speed = 2'd1;
                        end
                    end
                end
                if (falls[1] && n_fan_on) begin
                    n_speed = (n_speed == 2'd3) ? 2'd1 : n_speed + 2'd1;
                end
                sum = {1'b0, n_count} + {1'b0, r_timer_step};
                if (falls[2] && sum < {1'b0, r_timer_limit}) begin
                    n_count = sum[7:0];
                    n_tarm  = 1'b1;
                end
                n_prev = r_in.button_levels;
            end
            OP_TICK: begin
                if (r_tarm) begin
                    if (r_count != 8'd0) begin
                        n_count = r_count - 8'd1;
                    end else begin
                        n_fan_on = 1'b0;
                        n_speed  = 2'd0;
                        n_tarm   = 1'b0;
                    end
                end
            end
            OP_ECHO: begin
                // Too far away: switch a running fan off
                if (r_fan_on && {1'b0, r_dist_limit} < w_dist) begin
                    n_fan_on = 1'b0;
                    n_speed  = 2'd0;
                    n_tarm   = 1'b0;
                    n_count  = 8'd0;
                end
            end
            default: ;
        endcase

        n_out.fan_running  = n_fan_on;
        n_out.speed_now    = n_speed;
        n_out.seconds_left = n_count;
        n_out.timer_armed  = n_tarm;
        n_out.range_mm     = w_dist;
        case (n_speed)
            2'd1: begin
                n_out.pwm_compare = w_cmp1;
                n_out.led_rgb     = 3'b001;
            end
            2'd2: begin
                n_out.pwm_compare = w_cmp2;
                n_out.led_rgb     = 3'b010;
            end
            2'd3: begin
                n_out.pwm_compare = r_pwm_period;
                n_out.led_rgb     = 3'b100;
            end
            default: begin
                n_out.pwm_compare = 16'd0;
                n_out.led_rgb     = 3'b000;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_fan_on <= 1'b0;
            r_speed  <= 2'd0;
            r_count  <= 8'd0;
            r_tarm   <= 1'b0;
            r_prev   <= 3'b111;
        end else begin
            // Take a new word whenever the input register frees up
            if (i_in.ready) begin
                r_in_v <= i_in.valid;
            end
            if (w_adv) begin
                r_out_v <= r_in_v;
            end
            // Commit the state together with the result word
            if (w_adv && r_in_v) begin
                r_fan_on <= n_fan_on;
                r_speed  <= n_speed;
                r_count  <= n_count;
                r_tarm   <= n_tarm;
                r_prev   <= n_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (w_adv && r_in_v) begin
            r_out <= n_out;
        end
    end

endmodule

// File: sv/fst_checker.sv
module fst_checker import fst_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    // An empty output side never blocks the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // Speed is zero exactly when the fan is off
    a_speed_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.fan_running == (i_out_data.speed_now != 2'd0)))
        else $error("speed and power disagree");

    // LED shows one color that matches the speed level
    a_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0(i_out_data.led_rgb) &&
            ((i_out_data.led_rgb == 3'b000) == (i_out_data.speed_now == 2'd0)) &&
            (i_out_data.led_rgb[2] == (i_out_data.speed_now == 2'd3)))
        else $error("LED does not match speed");

endmodule

bind fan_speed_timer_controller fst_checker u_fst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// File: tb/fan_state_checker.sv
module fan_state_checker import fst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    fst_in_if    i_in,
    fst_out_if   i_out,
    fst_cfg_if   i_cfg,
    output int   o_pending,
    output int   o_checked,
    output int   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] LED_OFF   = 3'b000;
    localparam logic [2:0] LED_GREEN = 3'b001;
    localparam logic [2:0] LED_BLUE  = 3'b010;
    localparam logic [2:0] LED_RED   = 3'b100;
    localparam int         SHOW_MAX  = 10;

    // Register copies
    logic [15:0] period;
    logic [12:0] dist_limit;
    logic [7:0]  tmr_limit;
    logic [7:0]  tmr_step;

    // Fan state copies
    logic        fan_on;
    logic [1:0]  speed_lvl;
    logic [7:0]  secs;
    logic        armed;
    logic [2:0]  last_levels;

    t_out_word   expected_states[$];
    int          errs;
    int          n_checked;

    function automatic void fan_stop();
        fan_on    = 1'b0;
        speed_lvl = 2'd0;
        armed     = 1'b0;
    endfunction

    // Advance the fan state by one word and return the state it leaves.
    function automatic t_out_word fan_after_word(t_in_word w);
        logic [2:0]  falls;
        logic [8:0]  sum;
        int unsigned mm;
        int unsigned per;
        t_out_word   r;
        mm  = 0;
        per = period;
        case (w.op)
            OP_BUTTONS: begin
                falls = last_levels & ~w.button_levels;
                if (falls[0]) begin
                    if (fan_on) begin
                        fan_stop();
                        secs = 8'd0;
                    end else begin
                        fan_on = 1'b1;
                        if (speed_lvl == 2'd0) speed_lvl = 2'd1;
                    end
                end
                if (falls[1] && fan_on) begin
                    speed_lvl = (speed_lvl == 2'd3) ? 2'd1 : speed_lvl + 2'd1;
                end
                if (falls[2]) begin
                    sum = 9'(secs) + 9'(tmr_step);
                    if (sum < 9'(tmr_limit)) begin
                        secs  = sum[7:0];
                        armed = 1'b1;
                    end
                end
                last_levels = w.button_levels;
            end
            OP_TICK: begin
                if (armed) begin
                    if (secs != 8'd0) secs = secs - 8'd1;
                    else fan_stop();
                end
            end
            OP_ECHO: begin
                if (w.echo_ok) begin
                    mm = w.echo_width_us;
                    mm = mm * 343 / 2000;
                    if (fan_on && mm > dist_limit) begin
                        fan_stop();
                        secs = 8'd0;
                    end
                end
            end
            default: ;
        endcase

        r.fan_running  = fan_on;
        r.speed_now    = speed_lvl;
        r.seconds_left = secs;
        r.timer_armed  = armed;
        r.range_mm     = 14'(mm);
        case (speed_lvl)
            2'd1: begin
                r.pwm_compare = 16'(per * 3 / 5);
                r.led_rgb     = LED_GREEN;
            end
            2'd2: begin
                r.pwm_compare = 16'(per * 4 / 5);
                r.led_rgb     = LED_BLUE;
            end
            2'd3: begin
                r.pwm_compare = period;
                r.led_rgb     = LED_RED;
            end
            default: begin
                r.pwm_compare = 16'd0;
                r.led_rgb     = LED_OFF;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errs++;
            if (errs <= SHOW_MAX) begin
                $display("%0t: result %0d, %s: expected %0d, got %0d",
                         $time, n_checked, fname, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            period      = PWM_PERIOD_RST;
            dist_limit  = DIST_LIMIT_RST;
            tmr_limit   = TIMER_LIMIT_RST;
            tmr_step    = TIMER_STEP_RST;
            fan_on      = 1'b0;
            speed_lvl   = 2'd0;
            secs        = 8'd0;
            armed       = 1'b0;
            last_levels = 3'b111;
            expected_states.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.index)
                    REG_PWM_PERIOD:  period     = i_cfg.data.data;
                    REG_DIST_LIMIT:  dist_limit = i_cfg.data.data[12:0];
                    REG_TIMER_LIMIT: tmr_limit  = i_cfg.data.data[7:0];
                    REG_TIMER_STEP:  tmr_step   = i_cfg.data.data[7:0];
                    default: ;
                endcase
            end
            // Compare before queueing: a word taken at this edge cannot leave at it.
            if (i_out.valid && i_out.ready) begin
                if (expected_states.size() == 0) begin
                    errs++;
                    if (errs <= SHOW_MAX) begin
                        $display("%0t: result word with nothing outstanding", $time);
                    end
                end else begin
                    want = expected_states.pop_front();
                    check_field("fan_running",  want.fan_running,  i_out.data.fan_running);
                    check_field("speed_now",    want.speed_now,    i_out.data.speed_now);
                    check_field("pwm_compare",  want.pwm_compare,  i_out.data.pwm_compare);
                    check_field("led_rgb",      want.led_rgb,      i_out.data.led_rgb);
                    check_field("seconds_left", want.seconds_left, i_out.data.seconds_left);
                    check_field("timer_armed",  want.timer_armed,  i_out.data.timer_armed);
                    check_field("range_mm",     want.range_mm,     i_out.data.range_mm);
                    n_checked++;
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_states.push_back(fan_after_word(i_in.data));
            end
        end
        o_pending    <= expected_states.size();
        o_checked    <= n_checked;
        o_fail_count <= errs;
    end

endmodule

// File: tb/tb_top.sv
module tb_top import fst_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Op value the block leaves unused; it must report state without change.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Active-low button masks: a cleared bit is a pressed button.
    localparam logic [2:0] BTN_POWER = 3'b001;
    localparam logic [2:0] BTN_SPEED = 3'b010;
    localparam logic [2:0] BTN_TIMER = 3'b100;
    localparam logic [2:0] BTN_NONE  = 3'b111;

    localparam int N_SETTINGS     = 7;
    localparam int PHASE_ITEMS    = 95;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk;
    logic i_rst_n;

    fst_in_if  in_ch ();
    fst_out_if out_ch ();
    fst_cfg_if cfg_ch ();

    int          pending;
    int          checked;
    int          fail_count;
    int          idle_cycles = 0;
    int          n_words [4];
    int          n_settings;
    bit          steady;
    logic [12:0] cur_dist_limit;

    fan_speed_timer_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    fan_state_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    // Return zero throughout a steady stretch so the block runs flat out.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Build one random word. Most are well-formed presses and releases,
    // ticks, and echoes near the distance limit; the rest is noise.
    function automatic t_in_word random_word();
        t_in_word w;
        int       r;
        int       thr;
        w.button_levels = 3'($urandom);
        w.echo_width_us = 16'($urandom);
        w.echo_ok       = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45) begin
            w.op = OP_BUTTONS;
            r = $urandom_range(0, 99);
            if (r < 45)      w.button_levels = BTN_NONE;
            else if (r < 55) w.button_levels = ~BTN_POWER;
            else if (r < 75) w.button_levels = ~BTN_SPEED;
            else if (r < 93) w.button_levels = ~BTN_TIMER;
        end else if (r < 70) begin
            w.op = OP_TICK;
        end else if (r < 95) begin
            w.op      = OP_ECHO;
            w.echo_ok = ($urandom_range(0, 9) != 0);
            // Aim most echoes at the switch-off threshold.
            if ($urandom_range(0, 99) < 60) begin
                thr = (int'(cur_dist_limit) + 1) * 2000 / 343
                      + int'($urandom_range(0, 40)) - 20;
                if (thr < 0) thr = 0;
                if (thr > 65535) thr = 65535;
                w.echo_width_us = 16'(thr);
            end
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    // Offer one word after a random gap and hold it until taken.
    // Leave valid high afterwards so back-to-back words need no toggle.
    task automatic send_word(t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.data  <= w;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        n_words[w.op]++;
    endtask

    task automatic send_fields(logic [1:0] op, logic [2:0] lv, logic [15:0] wd, logic ok);
        t_in_word w;
        w.op            = op;
        w.button_levels = lv;
        w.echo_width_us = wd;
        w.echo_ok       = ok;
        send_word(w);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [15:0] val);
        cfg_ch.data  <= '{index: idx, data: val};
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Write all four registers back to back, then drop valid once.
    task automatic set_regs(logic [15:0] per, logic [12:0] dlim, logic [7:0] tlim,
                            logic [7:0] tstep);
        put_reg(REG_PWM_PERIOD, per);
        put_reg(REG_DIST_LIMIT, 16'(dlim));
        put_reg(REG_TIMER_LIMIT, 16'(tlim));
        put_reg(REG_TIMER_STEP, 16'(tstep));
        cfg_ch.valid   <= 1'b0;
        cur_dist_limit  = dlim;
        n_settings++;
    endtask

    // Stop offering words and wait until every result has come back.
    // Always wait for an edge first: the outstanding count is registered and lags acceptance.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: alternate random ready runs with random stalls.
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Watchdog: end the run if no channel moves a word for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [7:0] tlim;
        n_settings     = 0;
        steady         = 1'b0;
        cur_dist_limit = DIST_LIMIT_RST;
        foreach (n_words[k]) n_words[k] = 0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a timer limit of 6 with a step of 3 lets one press
        // land and the next one hit the limit exactly.
        set_regs(PWM_PERIOD_RST, DIST_LIMIT_RST, 8'd6, 8'd3);

        // Unused op with the echo fields at their top values and all levels low: nothing moves.
        send_fields(OP_UNUSED, 3'b000, 16'hFFFF, 1'b1);
        // Tick with the timer disarmed, levels all low but ignored.
        send_fields(OP_TICK, 3'b000, 16'h0000, 1'b0);
        // Longest echo with the fan off: distance only.
        send_fields(OP_ECHO, 3'b000, 16'hFFFF, 1'b1);
        // Echo timeout reports zero.
        send_fields(OP_ECHO, BTN_NONE, 16'd5555, 1'b0);
        // Timer press with the fan off still arms the timer.
        send_fields(OP_BUTTONS, ~BTN_TIMER, 16'hFFFF, 1'b1);
        send_fields(OP_BUTTONS, BTN_NONE, 16'h0000, 1'b0);
        // Second press would reach the limit: count and armed flag hold.
        send_fields(OP_BUTTONS, ~BTN_TIMER, 16'h0000, 1'b0);
        // Power and speed fall in one sample: on at level 1, then level 2.
        send_fields(OP_BUTTONS, 3'b000, 16'h0000, 1'b0);
        // Tick with released levels: levels ignored, count goes down.
        send_fields(OP_TICK, BTN_NONE, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, BTN_NONE, 16'h0000, 1'b0);
        // Speed to 3, then wrap to 1.
        send_fields(OP_BUTTONS, ~BTN_SPEED, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, BTN_NONE, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, ~BTN_SPEED, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, BTN_NONE, 16'h0000, 1'b0);
        // Count down to zero, then the tick at zero switches the fan off.
        send_fields(OP_TICK, BTN_NONE, 16'h0000, 1'b0);
        send_fields(OP_TICK, BTN_NONE, 16'h0000, 1'b0);
        send_fields(OP_TICK, BTN_NONE, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, ~BTN_POWER, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, BTN_NONE, 16'h0000, 1'b0);
        // Distance exactly at the limit keeps running; one millimeter over stops.
        send_fields(OP_ECHO, BTN_NONE, 16'd1750, 1'b1);
        send_fields(OP_ECHO, BTN_NONE, 16'd1756, 1'b1);
        // Power off with the timer armed clears the count.
        send_fields(OP_BUTTONS, ~BTN_POWER, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, BTN_NONE, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, ~BTN_TIMER, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, 3'b010, 16'h0000, 1'b0);
        send_fields(OP_BUTTONS, BTN_NONE, 16'h0000, 1'b0);
        // Shortest echo.
        send_fields(OP_ECHO, BTN_NONE, 16'h0000, 1'b1);

        // Random part: one phase per register setting, each with a stretch
        // of back-to-back traffic on both sides.
        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            drain();
            case (ph)
                0: set_regs(PWM_PERIOD_RST, DIST_LIMIT_RST, TIMER_LIMIT_RST, TIMER_STEP_RST);
                1: set_regs(16'hFFFF, 13'h1FFF, 8'hFF, 8'd1);
                2: set_regs(16'd1, 13'd0, 8'd0, 8'hFF);
                // Period 0 gives compare 0; a step of 0 arms without adding.
                3: set_regs(16'd0, 13'h1FFF, 8'd40, 8'd0);
                default: begin
                    tlim = 8'($urandom_range(8, 255));
                    set_regs(16'($urandom_range(1, 65535)), 13'($urandom), tlim,
                             8'($urandom_range(1, 1 + tlim / 4)));
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                steady = (k >= 30 && k < 50);
                send_word(random_word());
            end
            steady = 1'b0;
        end

        drain();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d words: %0d button samples, %0d ticks, %0d echoes, %0d unused op,",
                 n_words[0] + n_words[1] + n_words[2] + n_words[3],
                 n_words[OP_BUTTONS], n_words[OP_TICK], n_words[OP_ECHO], n_words[OP_UNUSED]);
        $display("over %0d register settings; %0d results compared, %0d mismatches.",
                 n_settings, checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
